@@ hw/rtl/crng_pkg.sv @@
// Package for the combined LCG shuffle generator: moduli, multipliers,
// sequencer state type and the control bundle of the shared multiply-modulo unit.
// No dependencies.
`timescale 1ns / 1ps

package crng_pkg;

    // Generator one and two: moduli and multipliers.
    localparam logic [31:0] MOD_A = 32'd2147483563;
    localparam logic [31:0] MOD_B = 32'd2147483399;
    localparam logic [15:0] MUL_A = 16'd40014;
    localparam logic [15:0] MUL_B = 16'd40692;

    // 2^31 minus each modulus, used to fold the high part of a product.
    localparam logic [7:0] FOLD_A = 8'd85;
    localparam logic [7:0] FOLD_B = 8'd249;

    // Largest output value, one below the first modulus.
    localparam logic [31:0] IMM1 = 32'd2147483562;

    // Extra warm-up steps beyond the table length.
    localparam int WARM_EXTRA = 8;

    // Default shuffle table length.
    localparam int TABLE_SIZE_DEF = 32;

    // Which generator a multiply-modulo pass works for.
    typedef enum logic {
        GEN_A,
        GEN_B
    } gen_sel_t;

    // Control of the shared multiply-modulo unit.
    typedef struct packed {
        logic     mul_en;
        logic     fold_en;
        gen_sel_t sel;
    } mm_ctrl_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_W_MUL,
        ST_W_FOLD,
        ST_W_WB,
        ST_D_MUL_A,
        ST_D_FOLD_A,
        ST_D_MUL_B,
        ST_D_FOLD_B,
        ST_D_OUT
    } state_t;

endpackage

@@ hw/rtl/crng_mulmod.sv @@
// Shared multiply-modulo unit: computes z * mul mod m for either generator
// in two registered passes (multiply, then fold). Depends on crng_pkg.
`timescale 1ns / 1ps

module crng_mulmod (
    input  logic                clk,
    input  crng_pkg::mm_ctrl_t  ctrl,
    input  logic [30:0]         operand,
    output logic [30:0]         result
);
    import crng_pkg::*;

    logic [15:0] mul;
    logic [46:0] prod_next;
    logic [46:0] prod_reg;
    gen_sel_t    prod_sel_reg;
    logic [7:0]  fold_c;
    logic [31:0] fold_next;
    logic [31:0] fold_reg;
    gen_sel_t    fold_sel_reg;
    logic [31:0] modulus;

    // First pass: full product of the operand and the generator's multiplier.
    always_comb
    begin
        mul       = (ctrl.sel == GEN_B) ? MUL_B : MUL_A;
        prod_next = 47'(operand) * 47'(mul);
    end

    // Second pass: since 2^31 is congruent to the fold constant, the high part
    // times that constant plus the low part keeps the residue and stays below
    // twice the modulus.
    always_comb
    begin
        fold_c    = (prod_sel_reg == GEN_B) ? FOLD_B : FOLD_A;
        fold_next = 32'(prod_reg[46:31]) * 32'(fold_c) + 32'(prod_reg[30:0]);
    end

    // Final compare and subtract brings the folded value into range.
    always_comb
    begin
        modulus = (fold_sel_reg == GEN_B) ? MOD_B : MOD_A;
        if (fold_reg >= modulus)
        begin
            result = 31'(fold_reg - modulus);
        end
        else
        begin
            result = fold_reg[30:0];
        end
    end

    // Pass registers, loaded only when the sequencer asks.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg     <= prod_next;
            prod_sel_reg <= ctrl.sel;
        end
        if (ctrl.fold_en)
        begin
            fold_reg     <= fold_next;
            fold_sel_reg <= prod_sel_reg;
        end
    end

endmodule

@@ hw/rtl/combined_lcg_shuffle_rng.sv @@
// Top level of the combined LCG generator with Bays-Durham shuffle table.
// Depends on crng_pkg and crng_mulmod.
`timescale 1ns / 1ps

// Each request returns one sample in 1..2147483562, and the block takes no
// new request until the draw is through: both generators pass in turn
// through one shared multiply-modulo unit (multiply, fold, write back),
// with the shuffle table read and written in between. A request with reseed
// set, and the first request after reset, first runs seeding: a seed
// reduction step, then TABLE_SIZE+8 warm-up steps of multiply, fold and
// write back, during which the table is filled.
// The seed register is written through its own valid/ready port while the
// block is idle; a finished sample waits in the output register and does not
// keep the block from accepting the next request.
module combined_lcg_shuffle_rng #(
    parameter int TABLE_SIZE = crng_pkg::TABLE_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               seed_valid,
    output logic               seed_ready,
    input  logic signed [31:0] seed,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               reseed,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [30:0]        sample
);
    import crng_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + WARM_EXTRA);
    localparam longint unsigned SLOT_DIV_L = 64'd1 + 64'(IMM1) / 64'(TABLE_SIZE);
    localparam longint unsigned RECIP_L    = (64'd1 << 32) / SLOT_DIV_L;
    localparam logic [30:0] SLOT_DIV = SLOT_DIV_L[30:0];
    localparam logic [8:0]  RECIP    = RECIP_L[8:0];

    state_t state_reg, state_next;
    logic                  seeded_reg, seeded_next;
    logic                  out_valid_reg, out_valid_next;
    logic signed [31:0]    seed_reg;
    logic [CNT_W-1:0]      step_reg, step_next;
    logic [30:0]           first_gen_reg, first_gen_next;
    logic [30:0]           second_gen_reg, second_gen_next;
    logic [30:0]           last_output_reg, last_output_next;
    logic [30:0]           sample_reg, sample_next;
    logic [7:0]            qest_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [30:0]           rd_data_reg;

    logic                  in_accept;
    logic                  out_free;
    logic                  out_load;
    mm_ctrl_t              mm_ctrl;
    logic [30:0]           mm_operand;
    logic [30:0]           mm_result;
    logic [31:0]           seed_mag;
    logic [30:0]           seed_start;
    logic [39:0]           qprod;
    logic [39:0]           slot_bound;
    logic [8:0]            slot_fix;
    logic [IDX_W-1:0]      slot_next;
    logic                  mem_we;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_addr;
    logic [31:0]           diff;
    logic [31:0]           diff_wrap;

    logic [30:0] table_mem [TABLE_SIZE];

    assign in_accept  = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign seed_ready = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample     = sample_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // Shared multiply-modulo unit.
    crng_mulmod u_mulmod (
        .clk     (clk),
        .ctrl    (mm_ctrl),
        .operand (mm_operand),
        .result  (mm_result)
    );

    // Seed magnitude, zero taken as one, reduced once by the first modulus.
    always_comb
    begin
        if (seed_reg[31])
        begin
            seed_mag = 32'(~seed_reg) + 32'd1;
        end
        else
        begin
            seed_mag = seed_reg;
        end
        if (seed_reg == 32'sd0)
        begin
            seed_mag = 32'd1;
        end
        if (seed_mag >= MOD_A)
        begin
            seed_mag = seed_mag - MOD_A;
        end
        if (seed_mag == 32'd0)
        begin
            seed_mag = 32'd1;
        end
        seed_start = seed_mag[30:0];
    end

    // Slot from the previous output: reciprocal estimate, then one correction
    // step and a guard against the last slot.
    always_comb
    begin
        qprod      = 40'(last_output_reg) * 40'(RECIP);
        slot_bound = 40'({1'b0, qest_reg} + 9'd1) * 40'(SLOT_DIV);
        slot_fix   = {1'b0, qest_reg} + 9'(40'(last_output_reg) >= slot_bound);
        if (slot_fix >= 9'(TABLE_SIZE))
        begin
            slot_next = IDX_W'(TABLE_SIZE - 1);
        end
        else
        begin
            slot_next = slot_fix[IDX_W-1:0];
        end
    end

    // Old table entry minus generator two, wrapped into the output range.
    always_comb
    begin
        diff      = {1'b0, rd_data_reg} - {1'b0, mm_result};
        diff_wrap = diff + IMM1;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (reseed || !seeded_reg)
                    begin
                        state_next = ST_SEED;
                    end
                    else
                    begin
                        state_next = ST_D_MUL_A;
                    end
                end
            end
            ST_SEED:     state_next = ST_W_MUL;
            ST_W_MUL:    state_next = ST_W_FOLD;
            ST_W_FOLD:   state_next = ST_W_WB;
            ST_W_WB:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_D_MUL_A;
                end
                else
                begin
                    state_next = ST_W_MUL;
                end
            end
            ST_D_MUL_A:  state_next = ST_D_FOLD_A;
            ST_D_FOLD_A: state_next = ST_D_MUL_B;
            ST_D_MUL_B:  state_next = ST_D_FOLD_B;
            ST_D_FOLD_B: state_next = ST_D_OUT;
            ST_D_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath control and register updates for each state.
    always_comb
    begin
        seeded_next      = seeded_reg;
        step_next        = step_reg;
        first_gen_next   = first_gen_reg;
        second_gen_next  = second_gen_reg;
        last_output_next = last_output_reg;
        sample_next      = sample_reg;
        out_load         = 1'b0;
        mm_ctrl          = '{mul_en: 1'b0, fold_en: 1'b0, sel: GEN_A};
        mm_operand       = first_gen_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_addr         = slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SEED:
            begin
                first_gen_next  = seed_start;
                second_gen_next = seed_start;
                step_next       = CNT_W'(TABLE_SIZE + WARM_EXTRA - 1);
            end
            ST_W_MUL:
            begin
                mm_ctrl.mul_en = 1'b1;
            end
            ST_W_FOLD:
            begin
                mm_ctrl.fold_en = 1'b1;
            end
            ST_W_WB:
            begin
                // The last TABLE_SIZE warm-up values fill the table.
                first_gen_next = mm_result;
                mem_addr       = step_reg[IDX_W-1:0];
                mem_we         = (step_reg < CNT_W'(TABLE_SIZE));
                if (step_reg == '0)
                begin
                    last_output_next = mm_result;
                    seeded_next      = 1'b1;
                end
                else
                begin
                    step_next = step_reg - CNT_W'(1);
                end
            end
            ST_D_MUL_A:
            begin
                mm_ctrl.mul_en = 1'b1;
            end
            ST_D_FOLD_A:
            begin
                mm_ctrl.fold_en = 1'b1;
            end
            ST_D_MUL_B:
            begin
                // Swap generator one's new value into the slot, keep the old.
                first_gen_next = mm_result;
                mem_we         = 1'b1;
                mem_re         = 1'b1;
                mm_ctrl        = '{mul_en: 1'b1, fold_en: 1'b0, sel: GEN_B};
                mm_operand     = second_gen_reg;
            end
            ST_D_FOLD_B:
            begin
                mm_ctrl = '{mul_en: 1'b0, fold_en: 1'b1, sel: GEN_B};
            end
            ST_D_OUT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    second_gen_next = mm_result;
                    if (rd_data_reg > mm_result)
                    begin
                        sample_next = diff[30:0];
                    end
                    else
                    begin
                        sample_next = diff_wrap[30:0];
                    end
                    last_output_next = sample_next;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control and generator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            seeded_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            seed_reg        <= -32'sd1;
            step_reg        <= '0;
            first_gen_reg   <= '0;
            second_gen_reg  <= '0;
            last_output_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            seeded_reg      <= seeded_next;
            out_valid_reg   <= out_valid_next;
            step_reg        <= step_next;
            first_gen_reg   <= first_gen_next;
            second_gen_reg  <= second_gen_next;
            last_output_reg <= last_output_next;
            if (seed_valid && seed_ready)
            begin
                seed_reg <= seed;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        if (state_reg == ST_D_MUL_A)
        begin
            qest_reg <= qprod[39:32];
        end
        if (state_reg == ST_D_FOLD_A)
        begin
            slot_reg <= slot_next;
        end
    end

    // Shuffle table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_addr] <= first_gen_next;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_mem[slot_reg];
        end
    end

endmodule

@@ verif/tb.sv @@
// Testbench for combined_lcg_shuffle_rng: a directed table, then random requests under
// several idle and stall mixes, every sample checked against an in-bench generator model.
// Depends on the RTL top level combined_lcg_shuffle_rng only.
`timescale 1ns / 1ps

module tb;

    // Generator constants of the combined scheme.
    localparam longint unsigned GEN1_MOD = 64'd2147483563;
    localparam longint unsigned GEN2_MOD = 64'd2147483399;
    localparam longint unsigned GEN1_MUL = 64'd40014;
    localparam longint unsigned GEN2_MUL = 64'd40692;
    localparam longint unsigned OUT_MAX = GEN1_MOD - 64'd1;
    localparam int TABLE_LEN = 32;
    localparam int WARMUP_STEPS = TABLE_LEN + 8;
    localparam longint unsigned SLOT_DIV = 64'd1 + OUT_MAX / 64'(TABLE_LEN);

    localparam int PHASE_COUNT = 8;
    localparam int PHASE_REQUESTS = 75;
    localparam int DIRECTED_ROWS = 21;

    // One row of directed stimulus: optional seed write, then one request.
    typedef struct packed {
        logic        write_seed;
        logic [31:0] seed_value;
        logic        reseed_bit;
    } seed_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               seed_valid;
    logic               seed_ready;
    logic signed [31:0] seed;
    logic               in_valid;
    logic               in_stall;
    logic               reseed;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [30:0]        sample;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // Model state of the generator pair and the shuffle table.
    logic [31:0]       seed_word = 32'hFFFFFFFF;
    longint unsigned   gen1 = 0;
    longint unsigned   gen2 = 0;
    longint unsigned   prev_sample = 0;
    logic [30:0]       mix_table [TABLE_LEN];
    bit                seeded = 1'b0;
    logic [30:0]       pending_samples [$];

    seed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, 32'h00000000, 1'b0},    // first request seeds from the reset value of -1
        '{1'b0, 32'h00000000, 1'b0},
        '{1'b0, 32'h00000000, 1'b0},
        '{1'b0, 32'h00000000, 1'b1},    // reseed from -1 restarts the sequence
        '{1'b1, 32'h00000000, 1'b1},    // zero seed is taken as one
        '{1'b0, 32'h00000000, 1'b0},
        '{1'b1, 32'h80000000, 1'b1},    // most negative seed, magnitude 2^31
        '{1'b0, 32'h00000000, 1'b0},
        '{1'b1, 32'h7FFFFFFF, 1'b1},    // largest positive seed
        '{1'b1, 32'd2147483563, 1'b1},  // magnitude equal to the first modulus
        '{1'b1, 32'h80000055, 1'b1},    // negative first modulus
        '{1'b1, 32'd2147483399, 1'b1},  // second generator collapses to zero
        '{1'b0, 32'h00000000, 1'b0},
        '{1'b0, 32'h00000000, 1'b0},
        '{1'b0, 32'h00000000, 1'b0},
        '{1'b1, 32'h800000F9, 1'b1},    // negative second modulus
        '{1'b1, 32'h00000001, 1'b1},
        '{1'b1, 32'd2147483564, 1'b1},  // one above the first modulus wraps to one
        '{1'b1, 32'hFFFFFFFF, 1'b0},    // new seed does not act until a reseed
        '{1'b0, 32'h00000000, 1'b1},
        '{1'b0, 32'h00000000, 1'b0}
    };

    combined_lcg_shuffle_rng dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_valid (seed_valid),
        .seed_ready (seed_ready),
        .seed       (seed),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .reseed     (reseed),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample     (sample)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Seeding: magnitude of the seed reduced modulo the first modulus, then a
    // warm-up of the first generator whose last steps fill the table.
    function automatic void reload_from_seed();
        logic [31:0]     neg;
        longint unsigned mag;
        longint unsigned z;
        int              j;
        neg = ~seed_word + 32'd1;
        mag = seed_word[31] ? neg : seed_word;
        if (mag == 0)
            mag = 1;
        mag = mag % GEN1_MOD;
        if (mag == 0)
            mag = 1;
        z = mag;
        gen2 = z;
        for (j = WARMUP_STEPS - 1; j >= 0; j--)
        begin
            z = (z * GEN1_MUL) % GEN1_MOD;
            if (j < TABLE_LEN)
                mix_table[j] = z[30:0];
        end
        gen1 = z;
        prev_sample = {33'd0, mix_table[0]};
        seeded = 1'b1;
    endfunction

    // One draw: advance both generators, pick the slot from the previous sample,
    // return the slot minus generator two wrapped into 1..OUT_MAX.
    function automatic logic [30:0] draw_sample(input logic rs);
        longint unsigned slot;
        longint          diff;
        if (rs || !seeded)
            reload_from_seed();
        gen1 = (gen1 * GEN1_MUL) % GEN1_MOD;
        gen2 = (gen2 * GEN2_MUL) % GEN2_MOD;
        slot = prev_sample / SLOT_DIV;
        if (slot >= TABLE_LEN)
            slot = TABLE_LEN - 1;
        diff = longint'({33'd0, mix_table[slot]}) - longint'(gen2);
        mix_table[slot] = gen1[30:0];
        if (diff < 1)
            diff = diff + longint'(OUT_MAX);
        prev_sample = {33'd0, diff[30:0]};
        return prev_sample[30:0];
    endfunction

    // Receiver side: random stall at the rate of the current phase.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Monitor: seed writes, sample checks, then prediction for accepted requests.
    always @(posedge clk)
    begin
        logic [30:0] want;
        if (rst_n)
        begin
            if (seed_valid && seed_ready)
                seed_word = seed;
            if (out_valid && !out_stall)
            begin
                if (pending_samples.size() == 0)
                begin
                    $error("unexpected sample %0d with no request waiting", sample);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (sample !== want)
                    begin
                        $error("sample mismatch: expected %0d, got %0d", want, sample);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_samples.push_back(draw_sample(reseed));
        end
    end

    // Present one request, with random idle cycles ahead of it.
    task automatic send_request(input logic rs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        reseed <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Let every outstanding sample arrive.
    task automatic drain_samples();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_samples.size() != 0)
            @(posedge clk);
    endtask

    // Write the seed register once the block has gone idle.
    task automatic write_seed(input logic [31:0] value);
        drain_samples();
        seed_valid <= 1'b1;
        seed <= value;
        @(posedge clk);
        while (!seed_ready)
            @(posedge clk);
        seed_valid <= 1'b0;
    endtask

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        int          row;
        int          phase;
        int          n;
        logic [31:0] value;
        rst_n = 1'b0;
        seed_valid = 1'b0;
        seed = '0;
        in_valid = 1'b0;
        reseed = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (directed_rows[row].write_seed)
                write_seed(directed_rows[row].seed_value);
            send_request(directed_rows[row].reseed_bit);
        end

        // Idle mixes cycle through none, sender, receiver and both.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase % 2 == 0)
            begin
                value = $urandom;
            end
            else
            begin
                case ($urandom_range(3))
                    0: value = 32'h80000000;
                    1: value = 32'h7FFFFFFF;
                    2: value = 32'h00000000;
                    default: value = 32'hFFFFFFFF;
                endcase
            end
            write_seed(value);
            case (phase % 4)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 77; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 77; end
                default: begin send_idle_pct <= 11; recv_stall_pct <= 11; end
            endcase
            // Reseeding is slow, so only a small share of requests ask for it.
            for (n = 0; n < PHASE_REQUESTS; n++)
                send_request($urandom_range(15) == 0);
        end

        drain_samples();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
